@@ rtl/rqr_pkg.sv @@
// ----------------------------------------------------------------------------
// rqr_pkg
// Shared codes, widths and types of the ring queue with rear removal.
// ----------------------------------------------------------------------------
`default_nettype none

package rqr_pkg;

    // Field widths of the stream payloads
    localparam int OPCODE_W    = 3;
    localparam int DATA_W      = 32;
    localparam int ERR_W       = 2;
    localparam int CNT_W       = 5;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_FIELD_W = DATA_W + ERR_W + CNT_W + DATA_W + DATA_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Operation codes carried in s_tuser
    localparam logic [OPCODE_W-1:0] OP_ENQUEUE     = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_DEQUEUE     = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE_REAR = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_CLEAR       = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_STATUS      = 3'd4;

    // Error codes of a result
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    // Value returned by a removal from an empty queue
    localparam logic [DATA_W-1:0] REMOVED_EMPTY = '1;

    // Sequencer states
    typedef enum logic {
        RQR_IDLE,
        RQR_READ
    } rqr_state_t;

endpackage

`default_nettype wire

@@ rtl/rqr_mem.sv @@
// ----------------------------------------------------------------------------
// rqr_mem
// Slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rqr_mem #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32,
    parameter int IW        = 4
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [IW-1:0]        waddr,
    input  wire logic [WORD_BITS-1:0] wdata,
    input  wire logic                 re,
    input  wire logic [IW-1:0]        raddr,
    output logic      [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];

    // Write one slot
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read one slot into the registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/rqr_ctrl.sv @@
// ----------------------------------------------------------------------------
// rqr_ctrl
// Queue pointers, count, cached front and rear words, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rqr_ctrl #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32,
    parameter int IW        = 4,
    parameter int CW        = 5
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [rqr_pkg::IN_TDATA_W-1:0]    s_tdata,  // data_in
    input  wire logic [rqr_pkg::OPCODE_W-1:0]      s_tuser,  // opcode
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [rqr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                                   mem_we,
    output logic      [IW-1:0]                     mem_waddr,
    output logic      [WORD_BITS-1:0]              mem_wdata,
    output logic                                   mem_re,
    output logic      [IW-1:0]                     mem_raddr,
    input  wire logic [WORD_BITS-1:0]              mem_rdata,
    output logic      [CW-1:0]                     level
);

    import rqr_pkg::*;

    localparam int SW = CW + 1;

    rqr_state_t           state_reg,    state_next;
    logic [IW-1:0]        head_reg,     head_next;
    logic [CW-1:0]        count_reg,    count_next;
    logic [WORD_BITS-1:0] front_reg,    front_next;
    logic [WORD_BITS-1:0] rear_reg,     rear_next;
    logic                 pend_front_reg, pend_front_next;
    logic                 valid_reg,    valid_next;
    logic [DATA_W-1:0]    removed_reg,  removed_next;
    logic [ERR_W-1:0]     err_reg,      err_next;

    logic                 accept;
    logic [SW-1:0]        head_ext;
    logic [SW-1:0]        count_ext;
    logic [WORD_BITS-1:0] in_word;
    logic [DATA_W-1:0]    front_out;
    logic [DATA_W-1:0]    rear_out;

    // Fold an index sum below twice the depth back into range
    function automatic logic [IW-1:0] wrap_idx(input logic [SW-1:0] x);
        logic [SW-1:0] y;
        y = (x >= SW'(DEPTH)) ? (x - SW'(DEPTH)) : x;
        return y[IW-1:0];
    endfunction

    // Stored word from a 32-bit input value
    function automatic logic [WORD_BITS-1:0] to_word(input logic signed [DATA_W-1:0] d);
        return WORD_BITS'(d);
    endfunction

    // 32-bit result field from a stored word
    function automatic logic [DATA_W-1:0] to_field(input logic signed [WORD_BITS-1:0] w);
        return DATA_W'(w);
    endfunction

    assign accept    = s_tvalid && s_tready;
    assign head_ext  = SW'(head_reg);
    assign count_ext = SW'(count_reg);
    assign in_word   = to_word(s_tdata[DATA_W-1:0]);

    // Next state, slot accesses and result
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        front_next      = front_reg;
        rear_next       = rear_reg;
        pend_front_next = pend_front_reg;
        valid_next      = valid_reg;
        removed_next    = removed_reg;
        err_next        = err_reg;
        s_tready        = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = wrap_idx(head_ext + count_ext);
        mem_wdata       = in_word;
        mem_re          = 1'b0;
        mem_raddr       = wrap_idx(head_ext + SW'(1));

        // Drop the result once taken
        if (valid_reg && m_tready)
        begin
            valid_next = 1'b0;
        end

        case (state_reg)
            RQR_IDLE:
            begin
                s_tready = !valid_reg || m_tready;
                if (accept)
                begin
                    removed_next = '0;
                    err_next     = ERR_OK;
                    valid_next   = 1'b1;
                    case (s_tuser)
                        OP_ENQUEUE:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                err_next = ERR_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                rear_next  = in_word;
                                count_next = count_reg + CW'(1);
                                if (count_reg == '0)
                                begin
                                    front_next = in_word;
                                end
                            end
                        end
                        OP_DEQUEUE:
                        begin
                            if (count_reg == '0)
                            begin
                                removed_next = REMOVED_EMPTY;
                                err_next     = ERR_EMPTY;
                            end
                            else
                            begin
                                removed_next = to_field(front_reg);
                                head_next    = wrap_idx(head_ext + SW'(1));
                                count_next   = count_reg - CW'(1);
                                if (count_reg > CW'(1))
                                begin
                                    // Fetch the new front word
                                    mem_re          = 1'b1;
                                    mem_raddr       = wrap_idx(head_ext + SW'(1));
                                    pend_front_next = 1'b1;
                                    valid_next      = 1'b0;
                                    state_next      = RQR_READ;
                                end
                            end
                        end
                        OP_REMOVE_REAR:
                        begin
                            if (count_reg == '0)
                            begin
                                removed_next = REMOVED_EMPTY;
                                err_next     = ERR_EMPTY;
                            end
                            else
                            begin
                                removed_next = to_field(rear_reg);
                                count_next   = count_reg - CW'(1);
                                if (count_reg > CW'(1))
                                begin
                                    // Fetch the new rear word
                                    mem_re          = 1'b1;
                                    mem_raddr       = wrap_idx(head_ext + count_ext - SW'(2));
                                    pend_front_next = 1'b0;
                                    valid_next      = 1'b0;
                                    state_next      = RQR_READ;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            head_next  = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                            // Status query and unused codes leave the queue alone
                        end
                    endcase
                end
            end
            RQR_READ:
            begin
                // Refill the cached word and release the result
                if (pend_front_reg)
                begin
                    front_next = mem_rdata;
                end
                else
                begin
                    rear_next = mem_rdata;
                end
                valid_next = 1'b1;
                state_next = RQR_IDLE;
            end
            default:
            begin
                state_next = RQR_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RQR_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        front_reg      <= front_next;
        rear_reg       <= rear_next;
        pend_front_reg <= pend_front_next;
        removed_reg    <= removed_next;
        err_reg        <= err_next;
    end

    // Assemble the result from the settled queue state
    assign front_out = (count_reg == '0) ? '0 : to_field(front_reg);
    assign rear_out  = (count_reg == '0) ? '0 : to_field(rear_reg);
    assign m_tvalid  = valid_reg;
    assign m_tdata   = OUT_TDATA_W'({rear_out, front_out, CNT_W'(count_reg),
                                     err_reg, removed_reg});
    assign level     = count_reg;

endmodule

`default_nettype wire

@@ rtl/ring_queue_with_rear_removal.sv @@
// ----------------------------------------------------------------------------
// ring_queue_with_rear_removal
// Fixed-depth circular queue of signed words with front and rear removal.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel: s_tuser carries the opcode (enqueue,
//   dequeue front, remove rear, clear, status) and s_tdata the value. Each
//   request yields exactly one result on the m_ channel, carrying the
//   removed value, an error code, the count and the front and rear words.
//   The result register is loaded on acceptance, except when a dequeue or rear
//   removal leaves one or more entries: then the sequencer first reads the new
//   front or rear word through the single slot read port. Throughput is one
//   request per cycle while results are taken, but not during that read;
//   one request is in flight at a time.
//   Reset empties the queue (head and count to zero); slot contents are
//   left as they are and only live entries are ever read.
//   A stalled receiver holds the result register; s_tready stays low until
//   the result is taken, so no request is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_queue_with_rear_removal #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // data_in[31:0]
    input  wire logic [rqr_pkg::IN_TDATA_W-1:0]  s_tdata,
    // opcode[2:0]
    input  wire logic [rqr_pkg::OPCODE_W-1:0]    s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // removed_value[31:0], error_code[33:32], count[38:34],
    // front_word[70:39], rear_word[102:71], zero pad[103]
    output logic      [rqr_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import rqr_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic                 mem_we;
    logic [IW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [IW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;
    logic [CW-1:0]        level;

    // Pointer and result logic
    rqr_ctrl #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .IW        (IW),
        .CW        (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .level     (level)
    );

    // Slot store
    rqr_mem #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .IW        (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Never more entries than slots
    assert property (@(posedge clk) disable iff (!rst_n) level <= CW'(DEPTH))
        else $error("queue level exceeds depth");

    // A slot is never written and read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n) !(mem_we && mem_re))
        else $error("slot write and read overlap");

    // While a slot read is outstanding, no request is taken and no result shown
    assert property (@(posedge clk) disable iff (!rst_n) mem_re |=> !s_tready && !m_tvalid)
        else $error("request or result during slot read");

    // A full error is only reported with a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[33:32] == ERR_FULL)) |-> (level == CW'(DEPTH)))
        else $error("full error with free slots");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ring queue with rear removal.
// Drives requests on the s_ stream and checks every result on the m_ stream
// against a behavioural queue kept in step inside the bench. A directed pass
// covers the empty, full, wrap and clear corners. A randomised pass of
// fill-heavy, drain-heavy and mixed phases follows. Both sides of the
// stream pause at random.
// ----------------------------------------------------------------------------

module tb_top;

    import rqr_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_COUNT  = 20;
    localparam int PHASE_ITEMS  = 40;

    // Opcodes outside the defined set; the block treats them as status
    localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

    // Phase biases of the random traffic
    typedef enum int {
        BIAS_FILL,
        BIAS_DRAIN,
        BIAS_MIXED
    } phase_bias_t;

    typedef struct {
        logic [DATA_W-1:0] removed_value;
        logic [ERR_W-1:0]  error_code;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] front_word;
        logic [DATA_W-1:0] rear_word;
    } queue_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [OPCODE_W-1:0]    s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Shadow copy of the queue
    logic [DATA_W-1:0] ring_words [QUEUE_DEPTH];
    int                ring_head;
    int                ring_count;

    queue_result_t predicted_results [$];

    int  error_count;
    int  cycle_count;
    int  burst_left;
    int  stall_left;
    bit  idle_enable;
    bit  stall_enable;

    ring_queue_with_rear_removal #(
        .DEPTH     (QUEUE_DEPTH),
        .WORD_BITS (DATA_W)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock, 2 ns period
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver back-pressure: bursts of stalls of random length
    always @(negedge clk)
    begin
        if (!stall_enable)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            stall_left = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Advance the shadow queue by one request and record the expected result
    task automatic predict_queue_op(input logic [OPCODE_W-1:0] opcode,
                                    input logic [DATA_W-1:0] value);
        queue_result_t expected;
        expected.removed_value = '0;
        expected.error_code    = ERR_OK;
        case (opcode)
            OP_ENQUEUE:
            begin
                if (ring_count >= QUEUE_DEPTH)
                    expected.error_code = ERR_FULL;
                else
                begin
                    ring_words[(ring_head + ring_count) % QUEUE_DEPTH] = value;
                    ring_count++;
                end
            end
            OP_DEQUEUE, OP_REMOVE_REAR:
            begin
                if (ring_count == 0)
                begin
                    expected.removed_value = REMOVED_EMPTY;
                    expected.error_code    = ERR_EMPTY;
                end
                else if (opcode == OP_DEQUEUE)
                begin
                    expected.removed_value = ring_words[ring_head];
                    ring_head  = (ring_head + 1) % QUEUE_DEPTH;
                    ring_count--;
                end
                else
                begin
                    expected.removed_value =
                        ring_words[(ring_head + ring_count - 1) % QUEUE_DEPTH];
                    ring_count--;
                end
            end
            OP_CLEAR:
            begin
                ring_head  = 0;
                ring_count = 0;
            end
            default:
            begin
                // status query and unused opcodes leave the state alone
            end
        endcase
        expected.count = ring_count[CNT_W-1:0];
        if (ring_count == 0)
        begin
            expected.front_word = '0;
            expected.rear_word  = '0;
        end
        else
        begin
            expected.front_word = ring_words[ring_head];
            expected.rear_word  = ring_words[(ring_head + ring_count - 1) % QUEUE_DEPTH];
        end
        predicted_results.push_back(expected);
    endtask

    // Send one request, pausing between bursts, and predict it on acceptance
    task automatic send_request(input logic [OPCODE_W-1:0] opcode,
                                input logic [DATA_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 10);
            gap = idle_enable ? $urandom_range(0, 4) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= opcode;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        predict_queue_op(opcode, value);
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic report_field(input string name, input logic [DATA_W-1:0] expected,
                                input logic [DATA_W-1:0] actual);
        if (expected !== actual)
        begin
            $error("%s: expected %h, got %h", name, expected, actual);
            error_count++;
        end
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        queue_result_t expected;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (predicted_results.size() == 0)
            begin
                $error("result with no request outstanding: %h", m_tdata);
                error_count++;
            end
            else
            begin
                expected = predicted_results.pop_front();
                report_field("removed_value", expected.removed_value, m_tdata[31:0]);
                report_field("error_code", DATA_W'(expected.error_code),
                             DATA_W'(m_tdata[33:32]));
                report_field("count", DATA_W'(expected.count), DATA_W'(m_tdata[38:34]));
                report_field("front_word", expected.front_word, m_tdata[70:39]);
                report_field("rear_word", expected.rear_word, m_tdata[102:71]);
            end
        end
    end

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OPCODE_W-1:0] pick_opcode(input phase_bias_t bias);
        int r;
        int enqueue_share;
        r = $urandom_range(0, 99);
        if (r < 2)
            return OP_CLEAR;
        if (r < 5)
            return OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        if (r < 10)
            return OP_STATUS;
        case (bias)
            BIAS_FILL:  enqueue_share = 75;
            BIAS_DRAIN: enqueue_share = 20;
            default:    enqueue_share = 50;
        endcase
        if ($urandom_range(0, 99) < enqueue_share)
            return OP_ENQUEUE;
        return $urandom_range(0, 1) ? OP_DEQUEUE : OP_REMOVE_REAR;
    endfunction

    // Empty removals, extreme words, wrap past the end, full, clear
    task automatic test_directed_corners();
        idle_enable  = 1'b1;
        stall_enable = 1'b1;
        send_request(OP_STATUS, '0);
        send_request(OP_DEQUEUE, 32'h1234_5678);
        send_request(OP_REMOVE_REAR, '0);
        send_request(OP_ENQUEUE, 32'h8000_0000);
        send_request(OP_ENQUEUE, 32'h7fff_ffff);
        send_request(OP_DEQUEUE, '0);
        send_request(OP_REMOVE_REAR, '0);
        send_request(OP_UNUSED_LO, '1);
        // head now sits at one, so filling wraps round the ring
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_request(OP_ENQUEUE, (i == 0) ? '1 : (i == 1) ? '0 : pick_word());
        send_request(OP_ENQUEUE, 32'h5555_aaaa);
        send_request(OP_CLEAR, '0);
        wait_drained();
    endtask

    // Random phases biased towards filling, draining or mixing
    task automatic test_random_traffic();
        phase_bias_t bias;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            bias         = phase_bias_t'($urandom_range(0, 2));
            idle_enable  = ($urandom_range(0, 3) != 0);
            stall_enable = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_request(pick_opcode(bias), pick_word());
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_STATUS;
        m_tready     = 1'b0;
        error_count  = 0;
        cycle_count  = 0;
        burst_left   = 0;
        stall_left   = 0;
        idle_enable  = 1'b0;
        stall_enable = 1'b0;
        ring_head    = 0;
        ring_count   = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_corners();
        test_random_traffic();

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/rqr_pkg.sv
rtl/rqr_mem.sv
rtl/rqr_ctrl.sv
rtl/ring_queue_with_rear_removal.sv
sim/tb_top.sv
